### rtl/aes128_pkg.sv
// aes128_pkg: constants, types and byte functions for the aes-128 encryption block
// used by aes128_block_encrypt; no dependencies
`timescale 1ns / 1ps
package aes128_pkg;

  localparam int unsigned NumRoundsDefault = 10;
  localparam int unsigned BlockW           = 128;
  localparam int unsigned KeyIdxW          = 4;

  typedef logic [BlockW-1:0] block_t;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StRun  = 3'b010,
    StOut  = 3'b100
  } state_e;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of the state sits at bits [127-8i -: 8]
  function automatic logic [7:0] get_byte(input block_t s, input int unsigned i);
    get_byte = s[BlockW-1-8*i -: 8];
  endfunction

  // subbytes and shiftrows, then mixcolumns unless last round
  function automatic block_t round_fn(input block_t s, input logic last);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, al;
    block_t     o;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[4*c+r] = SBOX[get_byte(s, 4*((c+r)%4)+r)];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
      al = a0 ^ a1 ^ a2 ^ a3;
      if (!last) begin
        t[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
        t[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
        t[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
        t[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) begin
      o[BlockW-1-8*i -: 8] = t[i];
    end
    round_fn = o;
  endfunction

endpackage

### rtl/aes128_block_encrypt.sv
// aes128_block_encrypt: iterative aes-128 encryption with a loaded round key store
// depends on aes128_pkg
`timescale 1ns / 1ps
// an encrypt item gets the initial key add, then one pass of the shared round unit per
// round; key 0 is read in the accept cycle
// the single round unit takes one block at a time and no item is accepted meanwhile; the
// result waits in an output register so the next item is accepted while it is pending, and a
// finished block waits in the state register while that output register is still full
// a key load item gives no result
// reset clears the sequencer and the output valid; the key store is undefined until loaded
module aes128_block_encrypt #(
  parameter int unsigned NUM_ROUNDS = aes128_pkg::NumRoundsDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata from bit 0: key_round[3:0], block_hi[67:4], block_lo[131:68], zero pad
  input  logic [135:0] s_axis_tdata,
  // tuser: mode (0 loads a round key, 1 encrypts)
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata from bit 0: cipher_hi[63:0], cipher_lo[127:64]
  output logic [127:0] m_axis_tdata
);
  import aes128_pkg::*;

  localparam int unsigned NumKeys = NUM_ROUNDS + 1;
  localparam int unsigned RndW    = $clog2(NumKeys + 1);
  localparam int unsigned AddrW   = $clog2(NumKeys);

  // round key memory, one 128-bit row per round key
  block_t key_mem [NumKeys];

  state_e          state_q, state_d;
  logic [RndW-1:0] rnd_q, rnd_d;     // round key index being read
  block_t          st_q, st_d;       // cipher state
  block_t          key_rd_q;         // registered key read data
  logic            first_q, first_d; // initial key add pending
  block_t          out_q;            // result waiting for the sink
  logic            out_vld_q, out_vld_d;

  logic [KeyIdxW-1:0] in_kidx;
  block_t             in_blk;
  logic               acc;
  logic               last_rnd;      // final round, no mixcolumns
  logic               out_free;      // output register can take a result
  logic               out_ld;
  block_t             rnd_out;       // shared round unit

  assign in_kidx = s_axis_tdata[KeyIdxW-1:0];
  assign in_blk  = {s_axis_tdata[KeyIdxW +: 64], s_axis_tdata[KeyIdxW+64 +: 64]};
  assign acc     = s_axis_tvalid && s_axis_tready;

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_q[63:0], out_q[127:64]};

  assign last_rnd = (32'(rnd_q) == NUM_ROUNDS + 1);
  assign out_free = !out_vld_q || m_axis_tready;
  assign rnd_out  = round_fn(st_q, last_rnd) ^ key_rd_q;

  // key memory write on load items, registered read at the current round
  always_ff @(posedge clk_i) begin
    if (acc && !s_axis_tuser && (32'(in_kidx) <= NUM_ROUNDS)) begin
      key_mem[in_kidx[AddrW-1:0]] <= in_blk;
    end
    if (32'(rnd_q) <= NUM_ROUNDS) begin
      key_rd_q <= key_mem[rnd_q[AddrW-1:0]];
    end
  end

  always_comb begin
    state_d = state_q;
    rnd_d   = rnd_q;
    st_d    = st_q;
    first_d = first_q;
    out_ld  = 1'b0;
    unique case (state_q)
      StIdle: begin
        rnd_d = '0;
        if (acc && s_axis_tuser) begin
          // key 0 read starts now, add next cycle
          st_d    = in_blk;
          first_d = 1'b1;
          rnd_d   = RndW'(1);
          state_d = StRun;
        end
      end
      StRun: begin
        // key_rd_q holds key for round (rnd_q - 1)
        if (first_q) begin
          st_d    = st_q ^ key_rd_q;
          first_d = 1'b0;
        end else begin
          st_d = rnd_out;
        end
        rnd_d = rnd_q + RndW'(1);
        if (last_rnd) begin
          rnd_d = '0;
          if (out_free) begin
            out_ld  = 1'b1;
            state_d = StIdle;
          end else begin
            state_d = StOut;
          end
        end
      end
      StOut: begin
        // finished block waits here until the output register frees
        if (out_free) begin
          out_ld  = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (m_axis_tvalid && m_axis_tready) out_vld_d = 1'b0;
    if (out_ld) out_vld_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      rnd_q     <= '0;
      first_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rnd_q     <= rnd_d;
      first_q   <= first_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
    if (out_ld) out_q <= st_d;
  end

endmodule

### test/aes128_block_encrypt_tb.sv
// aes128_block_encrypt_tb: self-checking bench for the aes-128 block encryption core
// loads round keys, encrypts directed and random blocks, checks ciphertext against
// an internal cipher model; depends on aes128_pkg and aes128_block_encrypt
`timescale 1ns / 1ps
module aes128_block_encrypt_tb;
  import aes128_pkg::*;

  localparam int unsigned Rounds = NumRoundsDefault;
  localparam logic ModeLoad = 1'b0;
  localparam logic ModeEncrypt = 1'b1;
  localparam int unsigned StallLimit = 20000;

  // aes byte-level cipher model with its own key store
  class cipher_scoreboard;
    logic [63:0] key_words [2*(Rounds+1)];
    logic [127:0] pending_cipher [$];
    int errors;

    function new();
      errors = 0;
      foreach (key_words[i]) key_words[i] = '0;
    endfunction

    static function logic [7:0] dbl(logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function logic [127:0] encrypt(logic [127:0] pt);
      logic [7:0] st [16];
      logic [7:0] tmp [16];
      logic [127:0] rk;
      logic [7:0] a0, a1, a2, a3, al;
      for (int i = 0; i < 16; i++) st[i] = pt[127-8*i -: 8];
      for (int r = 0; r <= Rounds; r++) begin
        if (r > 0) begin
          for (int c = 0; c < 4; c++)
            for (int w = 0; w < 4; w++)
              tmp[4*c+w] = SBOX[st[4*((c+w)%4)+w]];
          st = tmp;
          if (r < Rounds) begin
            for (int c = 0; c < 4; c++) begin
              a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
              al = a0 ^ a1 ^ a2 ^ a3;
              st[4*c]   = a0 ^ al ^ dbl(a0 ^ a1);
              st[4*c+1] = a1 ^ al ^ dbl(a1 ^ a2);
              st[4*c+2] = a2 ^ al ^ dbl(a2 ^ a3);
              st[4*c+3] = a3 ^ al ^ dbl(a3 ^ a0);
            end
          end
        end
        rk = {key_words[2*r], key_words[2*r+1]};
        for (int i = 0; i < 16; i++) st[i] ^= rk[127-8*i -: 8];
      end
      for (int i = 0; i < 16; i++) encrypt[127-8*i -: 8] = st[i];
    endfunction

    // note an accepted input item
    function void note_item(logic mode, logic [3:0] idx, logic [63:0] hi, logic [63:0] lo);
      if (mode == ModeLoad) begin
        if (idx <= Rounds) begin
          key_words[2*idx] = hi;
          key_words[2*idx+1] = lo;
        end
      end else begin
        pending_cipher.push_back(encrypt({hi, lo}));
      end
    endfunction

    function void check_result(logic [127:0] tdata);
      logic [127:0] exp_c;
      if (pending_cipher.size() == 0) begin
        $display("%0t: unexpected result hi=%h lo=%h", $time, tdata[63:0], tdata[127:64]);
        errors++;
        return;
      end
      exp_c = pending_cipher.pop_front();
      if (tdata[63:0] !== exp_c[127:64]) begin
        $display("%0t: cipher_hi expected %h actual %h", $time, exp_c[127:64], tdata[63:0]);
        errors++;
      end
      if (tdata[127:64] !== exp_c[63:0]) begin
        $display("%0t: cipher_lo expected %h actual %h", $time, exp_c[63:0], tdata[127:64]);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [135:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;

  cipher_scoreboard sb = new();
  int idle_pct = 16;
  int quiet_cycles = 0;

  always #5 clk_i = ~clk_i;

  aes128_block_encrypt #(.NUM_ROUNDS(Rounds)) uut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  // result side: random stalls, check on handshake
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      m_axis_tready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > StallLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // drive one item, with a random gap before it, and hold until accepted
  task automatic send_item(logic mode, logic [3:0] idx, logic [63:0] hi, logic [63:0] lo);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= mode;
    s_axis_tdata <= {4'b0, lo, hi, idx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_item(mode, idx, hi, lo);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic load_all_keys();
    for (int k = 0; k <= Rounds; k++) send_item(ModeLoad, k[3:0], rand64(), rand64());
  endtask

  initial begin
    logic [3:0] idx;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: all-zero and all-one blocks under all-zero keys, then the fips-197 plaintext under all-one keys
    for (int k = 0; k <= Rounds; k++) send_item(ModeLoad, k[3:0], '0, '0);
    send_item(ModeEncrypt, 4'd0, '0, '0);
    send_item(ModeEncrypt, 4'd15, '1, '1);
    for (int k = 0; k <= Rounds; k++) send_item(ModeLoad, k[3:0], '1, '1);
    send_item(ModeEncrypt, 4'd0, 64'h0011223344556677, 64'h8899aabbccddeeff);
    // out-of-range key indexes are ignored
    send_item(ModeLoad, 4'd11, 64'h0123456789abcdef, 64'hfedcba9876543210);
    send_item(ModeLoad, 4'd15, rand64(), rand64());
    send_item(ModeEncrypt, 4'd0, 64'h8000000000000000, 64'h0000000000000001);

    // random: key reloads among many blocks, no idling in a middle stretch
    load_all_keys();
    for (int n = 0; n < 830; n++) begin
      idle_pct = (n >= 300 && n < 450) ? 0 : 16;
      if ($urandom_range(9) == 0) begin
        idx = 4'($urandom_range(15));
        send_item(ModeLoad, idx, rand64(), rand64());
      end else begin
        send_item(ModeEncrypt, 4'($urandom()), rand64(), rand64());
      end
    end
    s_axis_tvalid <= 1'b0;

    while (sb.pending_cipher.size() != 0) @(posedge clk_i);
    repeat (4 * (Rounds + 3)) @(posedge clk_i);
    if (sb.errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end
endmodule
